@@ rtl/cccv_pkg.sv @@
// Shared constants, types and tables of the CC/CV charge controller.
package cccv_pkg;

    localparam int CHANNELS      = 3;
    localparam int SAMPLE_WINDOW = 10;
    localparam int SOC_WINDOW    = 5;
    localparam int TABLE_USED    = 49;

    localparam int CH_W   = 2;
    localparam int CI_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW_W   = $clog2(SAMPLE_WINDOW + 1);
    localparam int SF_W   = $clog2(SOC_WINDOW + 1);
    localparam int SI_W   = (SAMPLE_WINDOW > 1) ? $clog2(SAMPLE_WINDOW) : 1;
    localparam int SOI_W  = (SOC_WINDOW > 1) ? $clog2(SOC_WINDOW) : 1;
    localparam int SA_D   = CHANNELS * SAMPLE_WINDOW;
    localparam int SOA_D  = CHANNELS * SOC_WINDOW;
    localparam int SA_W   = (SA_D > 1) ? $clog2(SA_D) : 1;
    localparam int SOA_W  = (SOA_D > 1) ? $clog2(SOA_D) : 1;
    localparam int SUM_W  = 17 + SW_W;
    localparam int SSUM_W = 7 + SF_W;
    localparam int DIV_W  = SUM_W;
    localparam int DVS_W  = (SW_W > SF_W) ? SW_W : SF_W;
    localparam int SR_W   = SUM_W + 5;
    localparam int TI_W   = 6;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 18;

    localparam logic [CFG_AW-1:0] REG_CRITICAL_TEMP    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_SAFE_TEMP        = 3'd1;
    localparam logic [CFG_AW-1:0] REG_TARGET_VOLTAGE   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_FAST_CURRENT     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_STANDARD_CURRENT = 3'd4;
    localparam logic [CFG_AW-1:0] REG_VOLTAGE_FLOOR    = 3'd5;

    localparam logic [1:0] MODE_STOP = 2'd0;
    localparam logic [1:0] MODE_STD  = 2'd1;
    localparam logic [1:0] MODE_FAST = 2'd2;

    localparam logic [6:0] FULL_SOC = 7'd100;
    localparam logic [6:0] MAX_DUTY = 7'd100;

    // thresholds in centivolts, descending, with the matching SoC percent
    localparam logic [8:0] SOC_THR [TABLE_USED] = '{
        9'd420, 9'd416, 9'd414, 9'd412, 9'd410, 9'd408, 9'd406, 9'd404, 9'd402,
        9'd399, 9'd396, 9'd394, 9'd391, 9'd389, 9'd387, 9'd385, 9'd383, 9'd381,
        9'd379, 9'd377, 9'd375, 9'd373, 9'd371, 9'd369, 9'd367, 9'd365, 9'd364,
        9'd363, 9'd362, 9'd361, 9'd360, 9'd359, 9'd358, 9'd357, 9'd356, 9'd355,
        9'd354, 9'd353, 9'd352, 9'd351, 9'd350, 9'd348, 9'd346, 9'd344, 9'd343,
        9'd340, 9'd330, 9'd310, 9'd300};
    localparam logic [6:0] SOC_VAL [TABLE_USED] = '{
        7'd100, 7'd98, 7'd96, 7'd94, 7'd92, 7'd90, 7'd88, 7'd86, 7'd84,
        7'd82, 7'd80, 7'd78, 7'd76, 7'd74, 7'd72, 7'd70, 7'd68, 7'd66,
        7'd64, 7'd62, 7'd60, 7'd58, 7'd56, 7'd54, 7'd52, 7'd50, 7'd48,
        7'd46, 7'd44, 7'd42, 7'd40, 7'd38, 7'd36, 7'd34, 7'd32, 7'd30,
        7'd28, 7'd26, 7'd24, 7'd22, 7'd20, 7'd18, 7'd16, 7'd14, 7'd12,
        7'd8, 7'd6, 7'd4, 7'd2};

    typedef enum logic [3:0] {
        OP_IDLE, OP_LOAD, OP_CLASS, OP_RDSAMP, OP_PREP, OP_SRCH, OP_WRSOC,
        OP_RDSOC, OP_DIVI, OP_DIVV, OP_DIVS, OP_DUTY, OP_OUTLD
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic stop;
        logic samp_last;
        logic soc_last;
        logic srch_done;
        logic div_done;
    } stat_t;

endpackage

@@ rtl/cccv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cccv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/cccv_div.sv @@
// Iterative restoring divider: sign-magnitude dividend, one quotient bit per cycle.
module cccv_div import cccv_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] num,
    input  logic [DVS_W-1:0] den,
    input  logic             neg,
    output logic             done,
    output logic [DIV_W-1:0] quo
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] q_reg;
    logic [DVS_W:0]   r_reg;
    logic [DVS_W-1:0] den_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             ge;

    assign trial = {r_reg[DVS_W-1:0], q_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            r_reg   <= '0;
            den_reg <= den;
            neg_reg <= neg;
        end else if (busy_reg) begin
            if (ge) begin
                r_reg <= trial - {1'b0, den_reg};
                q_reg <= {q_reg[DIV_W-2:0], 1'b1};
            end else begin
                r_reg <= trial;
                q_reg <= {q_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? (~q_reg + 1'b1) : q_reg;
endmodule

@@ rtl/cccv_datapath.sv @@
// Datapath: configuration, per-channel state, sample windows, SoC search, averages, duty step.
module cccv_datapath import cccv_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [CFG_DW-1:0]  cfg_wdata,
    input  logic [CH_W-1:0]    in_channel,
    input  logic               in_discharging,
    input  logic signed [17:0] in_temp,
    input  logic signed [15:0] in_cur,
    input  logic signed [15:0] in_volt,
    input  cmd_t               cmd,
    output stat_t              stat,
    output logic [CH_W-1:0]    o_channel,
    output logic [1:0]         o_mode,
    output logic               o_measured,
    output logic [15:0]        o_avg_v,
    output logic [15:0]        o_avg_i,
    output logic [6:0]         o_soc,
    output logic [6:0]         o_drep,
    output logic [6:0]         o_dnext
);
    typedef enum logic [1:0] {SEL_I, SEL_V, SEL_S} div_sel_t;

    localparam int CW = SUM_W + 1;

    logic signed [17:0] crit_reg, safe_reg;
    logic [14:0] tv_reg, fast_reg, std_reg, floor_reg;

    logic [SW_W-1:0]  fill_reg  [CHANNELS];
    logic [SI_W-1:0]  sptr_reg  [CHANNELS];
    logic [SF_W-1:0]  sfill_reg [CHANNELS];
    logic [SOI_W-1:0] soptr_reg [CHANNELS];
    logic [6:0]       duty_reg  [CHANNELS];
    logic [6:0]       socv_reg  [CHANNELS];

    logic [CH_W-1:0]    ch_reg;
    logic               dis_reg;
    logic signed [17:0] temp_reg;
    logic signed [15:0] cur_reg, volt_reg;

    logic [1:0]        mode_reg;
    logic [6:0]        duty_use_reg;
    logic [SI_W-1:0]   slot_reg;
    logic [SOI_W-1:0]  soslot_reg;
    logic [SW_W-1:0]   k_reg;
    logic              samp_v_reg, soc_v_reg;
    logic signed [SUM_W-1:0] si_reg;
    logic [SUM_W-1:0]  sv_reg;
    logic [SW_W-1:0]   ni_reg, nv_reg;
    logic [SSUM_W-1:0] ssum_reg;
    logic [SR_W-1:0]   lhs_reg;
    logic [TI_W-1:0]   tidx_reg;
    logic [6:0]        soc_new_reg;
    div_sel_t          sel_reg;
    logic [15:0]       avg_i_reg, avg_v_reg;
    logic [6:0]        soc_avg_reg;

    logic [1:0]  r_mode;
    logic        r_meas;
    logic [15:0] r_avgv, r_avgi;
    logic [6:0]  r_soc, r_drep, r_dnext;

    logic [CI_W-1:0]  ci;
    logic             ch_ok;
    logic             stop_c;
    logic [1:0]       mode_c;
    logic [SI_W-1:0]  slot_new;
    logic [SOI_W-1:0] soslot_new;
    logic             samp_we, soc_we;
    logic [SA_W-1:0]  samp_waddr, samp_raddr;
    logic [SOA_W-1:0] soc_waddr, soc_raddr;
    logic [31:0]      samp_q;
    logic [6:0]       soc_q;
    logic signed [15:0] q_cur, q_volt;
    logic [16:0]      q_mag;
    logic [10:0]      duty_x10;
    logic [17:0]      coef;
    logic [SR_W-1:0]  rhs;
    logic             hit, srch_done;
    logic             div_start, div_neg, div_done;
    logic [DIV_W-1:0] div_num, div_quo;
    logic [DVS_W-1:0] div_den;
    logic [14:0]      tgt_i;
    logic [CW-1:0]    v_lim, i_lim;
    logic             vcond, below;
    logic [6:0]       duty_new;

    function automatic logic [SI_W-1:0] ring_idx(input logic [SI_W-1:0] s,
                                                 input logic [SW_W-1:0] k);
        int sv, kv;
        sv = int'(s);
        kv = int'(k);
        return (sv >= kv) ? SI_W'(sv - kv) : SI_W'(sv + SAMPLE_WINDOW - kv);
    endfunction

    function automatic logic [SOI_W-1:0] soc_ring_idx(input logic [SOI_W-1:0] s,
                                                      input logic [SW_W-1:0] k);
        int sv, kv;
        sv = int'(s);
        kv = int'(k);
        return (sv >= kv) ? SOI_W'(sv - kv) : SOI_W'(sv + SOC_WINDOW - kv);
    endfunction

    assign ci     = CI_W'(ch_reg);
    assign ch_ok  = int'(ch_reg) < CHANNELS;
    assign stop_c = !dis_reg && ((temp_reg > crit_reg) || (socv_reg[ci] == FULL_SOC));
    assign mode_c = dis_reg ? MODE_STOP : ((temp_reg > safe_reg) ? MODE_STD : MODE_FAST);

    assign slot_new   = (int'(sptr_reg[ci]) == SAMPLE_WINDOW - 1) ? '0 : sptr_reg[ci] + 1'b1;
    assign soslot_new = (int'(soptr_reg[ci]) == SOC_WINDOW - 1) ? '0 : soptr_reg[ci] + 1'b1;

    assign samp_we    = (cmd.op == OP_CLASS) && ch_ok && !stop_c;
    assign samp_waddr = SA_W'(int'(ci) * SAMPLE_WINDOW + int'(slot_new));
    assign samp_raddr = SA_W'(int'(ci) * SAMPLE_WINDOW + int'(ring_idx(slot_reg, k_reg)));
    assign soc_we     = cmd.op == OP_WRSOC;
    assign soc_waddr  = SOA_W'(int'(ci) * SOC_WINDOW + int'(soslot_new));
    assign soc_raddr  = SOA_W'(int'(ci) * SOC_WINDOW + int'(soc_ring_idx(soslot_reg, k_reg)));

    cccv_ram #(.WIDTH(32), .DEPTH(SA_D)) u_samp_ram (
        .aclk(aclk), .we(samp_we), .waddr(samp_waddr), .wdata({volt_reg, cur_reg}),
        .raddr(samp_raddr), .rdata(samp_q)
    );

    cccv_ram #(.WIDTH(7), .DEPTH(SOA_D)) u_soc_ram (
        .aclk(aclk), .we(soc_we), .waddr(soc_waddr), .wdata(soc_new_reg),
        .raddr(soc_raddr), .rdata(soc_q)
    );

    assign q_cur    = samp_q[15:0];
    assign q_volt   = samp_q[31:16];
    assign q_mag    = q_cur[15] ? (17'd0 - {q_cur[15], q_cur}) : {1'b0, q_cur};
    assign duty_x10 = 11'(duty_use_reg) * 11'd10;

    // SoC table search: compensated compare while discharging
    assign coef = dis_reg ? (18'(SOC_THR[tidx_reg]) + 18'd377) * 18'd200
                          : 18'(SOC_THR[tidx_reg]) * 18'd20;
    assign rhs  = SR_W'(nv_reg) * SR_W'(coef);
    assign hit  = lhs_reg >= rhs;
    assign srch_done = hit || (int'(tidx_reg) == TABLE_USED - 1) || (nv_reg == '0);

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_neg   = 1'b0;
        case (cmd.op)
            OP_DIVI: begin
                div_start = 1'b1;
                div_neg   = si_reg[SUM_W-1];
                div_num   = si_reg[SUM_W-1] ? DIV_W'(-si_reg) : DIV_W'(si_reg);
                div_den   = DVS_W'(ni_reg);
            end
            OP_DIVV: begin
                div_start = 1'b1;
                div_num   = DIV_W'(sv_reg);
                div_den   = DVS_W'(nv_reg);
            end
            OP_DIVS: begin
                div_start = 1'b1;
                div_num   = DIV_W'(ssum_reg);
                div_den   = DVS_W'(sfill_reg[ci]);
            end
            default: ;
        endcase
    end

    cccv_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(div_den), .neg(div_neg), .done(div_done), .quo(div_quo)
    );

    // CC/CV step
    assign tgt_i = (mode_reg == MODE_FAST) ? fast_reg : std_reg;
    assign v_lim = CW'(tv_reg) * CW'(nv_reg);
    assign i_lim = CW'(tgt_i) * CW'(ni_reg);
    assign vcond = (nv_reg == '0) ? (tv_reg != '0) : (CW'(sv_reg) < v_lim);
    assign below = (ni_reg == '0) ? (tgt_i != '0) : ($signed(CW'(si_reg)) < $signed(i_lim));
    always_comb begin
        if (dis_reg) begin
            duty_new = '0;
        end else if (vcond && below) begin
            duty_new = (duty_use_reg >= MAX_DUTY) ? MAX_DUTY : duty_use_reg + 1'b1;
        end else begin
            duty_new = (duty_use_reg == '0) ? '0 : duty_use_reg - 1'b1;
        end
    end

    assign stat.skip      = !ch_ok;
    assign stat.stop      = stop_c;
    assign stat.samp_last = k_reg == fill_reg[ci] - 1'b1;
    assign stat.soc_last  = k_reg == SW_W'(sfill_reg[ci]) - 1'b1;
    assign stat.srch_done = srch_done;
    assign stat.div_done  = div_done;

    // configuration and per-channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crit_reg  <= 18'sd60000;
            safe_reg  <= 18'sd50000;
            tv_reg    <= 15'd8400;
            fast_reg  <= 15'd10000;
            std_reg   <= 15'd5000;
            floor_reg <= 15'd200;
            for (int c = 0; c < CHANNELS; c++) begin
                fill_reg[c]  <= '0;
                sptr_reg[c]  <= '0;
                sfill_reg[c] <= '0;
                soptr_reg[c] <= '0;
                duty_reg[c]  <= '0;
                socv_reg[c]  <= '0;
            end
            samp_v_reg <= 1'b0;
            soc_v_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_CRITICAL_TEMP:    crit_reg  <= cfg_wdata;
                    REG_SAFE_TEMP:        safe_reg  <= cfg_wdata;
                    REG_TARGET_VOLTAGE:   tv_reg    <= cfg_wdata[14:0];
                    REG_FAST_CURRENT:     fast_reg  <= cfg_wdata[14:0];
                    REG_STANDARD_CURRENT: std_reg   <= cfg_wdata[14:0];
                    REG_VOLTAGE_FLOOR:    floor_reg <= cfg_wdata[14:0];
                    default: ;
                endcase
            end
            samp_v_reg <= cmd.op == OP_RDSAMP;
            soc_v_reg  <= cmd.op == OP_RDSOC;
            if (cmd.op == OP_CLASS && ch_ok) begin
                if (stop_c || dis_reg) begin
                    duty_reg[ci] <= '0;
                end
                if (!stop_c) begin
                    sptr_reg[ci] <= slot_new;
                    if (int'(fill_reg[ci]) < SAMPLE_WINDOW) begin
                        fill_reg[ci] <= fill_reg[ci] + 1'b1;
                    end
                end
            end
            if (cmd.op == OP_WRSOC) begin
                soptr_reg[ci] <= soslot_new;
                if (int'(sfill_reg[ci]) < SOC_WINDOW) begin
                    sfill_reg[ci] <= sfill_reg[ci] + 1'b1;
                end
            end
            if (cmd.op == OP_DUTY) begin
                duty_reg[ci] <= duty_new;
                socv_reg[ci] <= soc_avg_reg;
            end
        end
    end

    // item payload, accumulators and result
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                ch_reg   <= in_channel;
                dis_reg  <= in_discharging;
                temp_reg <= in_temp;
                cur_reg  <= in_cur;
                volt_reg <= in_volt;
            end
            OP_CLASS: begin
                r_mode  <= MODE_STOP;
                r_meas  <= 1'b0;
                r_avgv  <= '0;
                r_avgi  <= '0;
                r_drep  <= '0;
                r_dnext <= '0;
                r_soc   <= (ch_ok && stop_c) ? socv_reg[ci] : 7'd0;
                mode_reg     <= mode_c;
                duty_use_reg <= dis_reg ? 7'd0 : duty_reg[ci];
                slot_reg     <= slot_new;
                k_reg        <= '0;
                si_reg       <= '0;
                sv_reg       <= '0;
                ni_reg       <= '0;
                nv_reg       <= '0;
            end
            OP_RDSAMP: k_reg <= k_reg + 1'b1;
            OP_PREP: begin
                lhs_reg  <= dis_reg ? SR_W'(sv_reg) * SR_W'(23) : SR_W'(sv_reg);
                tidx_reg <= '0;
            end
            OP_SRCH: begin
                tidx_reg <= tidx_reg + 1'b1;
                if (srch_done) begin
                    soc_new_reg <= (hit && nv_reg != '0) ? SOC_VAL[tidx_reg] : 7'd0;
                end
            end
            OP_WRSOC: begin
                soslot_reg <= soslot_new;
                k_reg      <= '0;
                ssum_reg   <= '0;
            end
            OP_RDSOC: k_reg <= k_reg + 1'b1;
            OP_DIVI: sel_reg <= SEL_I;
            OP_DIVV: sel_reg <= SEL_V;
            OP_DIVS: sel_reg <= SEL_S;
            OP_DUTY: begin
                r_mode  <= mode_reg;
                r_meas  <= 1'b1;
                r_avgv  <= avg_v_reg;
                r_avgi  <= avg_i_reg;
                r_soc   <= soc_avg_reg;
                r_drep  <= duty_use_reg;
                r_dnext <= duty_new;
            end
            OP_OUTLD: begin
                o_channel  <= ch_reg;
                o_mode     <= r_mode;
                o_measured <= r_meas;
                o_avg_v    <= r_avgv;
                o_avg_i    <= r_avgi;
                o_soc      <= r_soc;
                o_drep     <= r_drep;
                o_dnext    <= r_dnext;
            end
            default: ;
        endcase
        if (samp_v_reg) begin
            if (q_mag >= 17'(duty_x10)) begin
                si_reg <= si_reg + SUM_W'(q_cur);
                ni_reg <= ni_reg + 1'b1;
            end
            if (q_volt >= $signed({1'b0, floor_reg})) begin
                sv_reg <= sv_reg + SUM_W'(q_volt[14:0]);
                nv_reg <= nv_reg + 1'b1;
            end
        end
        if (soc_v_reg) begin
            ssum_reg <= ssum_reg + SSUM_W'(soc_q);
        end
        // empty windows average to zero
        if (div_done) begin
            case (sel_reg)
                SEL_I:   avg_i_reg <= (ni_reg == '0) ? 16'd0 : div_quo[15:0];
                SEL_V:   avg_v_reg <= (nv_reg == '0) ? 16'd0 : div_quo[15:0];
                SEL_S:   soc_avg_reg <= div_quo[6:0];
                default: ;
            endcase
        end
    end
endmodule

@@ rtl/cccv_ctrl.sv @@
// Controller: sequences one measurement through the datapath and runs the handshakes.
module cccv_ctrl import cccv_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);
    typedef enum logic [16:0] {
        S_IDLE     = 17'b00000000000000001,
        S_CLASS    = 17'b00000000000000010,
        S_SREAD    = 17'b00000000000000100,
        S_SDRAIN   = 17'b00000000000001000,
        S_PREP     = 17'b00000000000010000,
        S_SRCH     = 17'b00000000000100000,
        S_SOCWR    = 17'b00000000001000000,
        S_SOCRD    = 17'b00000000010000000,
        S_SOCDRAIN = 17'b00000000100000000,
        S_DI       = 17'b00000001000000000,
        S_WI       = 17'b00000010000000000,
        S_DV       = 17'b00000100000000000,
        S_WV       = 17'b00001000000000000,
        S_DS       = 17'b00010000000000000,
        S_WS       = 17'b00100000000000000,
        S_DUTY     = 17'b01000000000000000,
        S_OUT      = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CLASS;
                end
            end
            S_CLASS: begin
                cmd.op     = OP_CLASS;
                state_next = (stat.skip || stat.stop) ? S_OUT : S_SREAD;
            end
            S_SREAD: begin
                cmd.op = OP_RDSAMP;
                if (stat.samp_last) begin
                    state_next = S_SDRAIN;
                end
            end
            S_SDRAIN: state_next = S_PREP;
            S_PREP: begin
                cmd.op     = OP_PREP;
                state_next = S_SRCH;
            end
            S_SRCH: begin
                cmd.op = OP_SRCH;
                if (stat.srch_done) begin
                    state_next = S_SOCWR;
                end
            end
            S_SOCWR: begin
                cmd.op     = OP_WRSOC;
                state_next = S_SOCRD;
            end
            S_SOCRD: begin
                cmd.op = OP_RDSOC;
                if (stat.soc_last) begin
                    state_next = S_SOCDRAIN;
                end
            end
            S_SOCDRAIN: state_next = S_DI;
            S_DI: begin
                cmd.op     = OP_DIVI;
                state_next = S_WI;
            end
            S_WI: if (stat.div_done) begin
                state_next = S_DV;
            end
            S_DV: begin
                cmd.op     = OP_DIVV;
                state_next = S_WV;
            end
            S_WV: if (stat.div_done) begin
                state_next = S_DS;
            end
            S_DS: begin
                cmd.op     = OP_DIVS;
                state_next = S_WS;
            end
            S_WS: if (stat.div_done) begin
                state_next = S_DUTY;
            end
            S_DUTY: begin
                cmd.op     = OP_DUTY;
                state_next = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!ov_reg || m_tready) begin
                    cmd.op     = OP_OUTLD;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.op == OP_OUTLD) begin
            ov_next = 1'b1;
        end else if (m_tready) begin
            ov_next = 1'b0;
        end else begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = ov_reg;
endmodule

@@ rtl/cc_cv_charge_controller.sv @@
// Sequence: a stopped or unknown channel goes from classification straight to the output
// register; a measured item reads its sample window (up to 10 samples), searches the SoC
// table (49 entries), reads its SoC window (up to 5 values) and runs 3 divisions, so the
// table search and the bit-serial divider set its worst case.
// Throughput: one item in flight; the next transfer is taken as soon as the result is
// in the output register, even while it waits to be taken.
// Reset (synchronous, aresetn low): registers to defaults, fills, duty and SoC cleared.
module cc_cv_charge_controller import cccv_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [55:0]       s_tdata,  // discharging, temperature_mdeg, current_sample, voltage_sample
    input  logic [1:0]        s_tuser,  // channel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,  // mean voltage, mean current, soc_percent, duty_reported, duty_next
    output logic [4:0]        m_tuser   // out_channel, mode, measured
);
    cmd_t  cmd;
    stat_t stat;

    logic [CH_W-1:0] o_channel;
    logic [1:0]      o_mode;
    logic            o_measured;
    logic [15:0]     o_avg_v, o_avg_i;
    logic [6:0]      o_soc, o_drep, o_dnext;

    cccv_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .stat(stat), .cmd(cmd)
    );

    cccv_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .in_channel(s_tuser), .in_discharging(s_tdata[0]),
        .in_temp(s_tdata[18:1]), .in_cur(s_tdata[34:19]), .in_volt(s_tdata[50:35]),
        .cmd(cmd), .stat(stat),
        .o_channel(o_channel), .o_mode(o_mode), .o_measured(o_measured),
        .o_avg_v(o_avg_v), .o_avg_i(o_avg_i), .o_soc(o_soc),
        .o_drep(o_drep), .o_dnext(o_dnext)
    );

    assign m_tdata = {3'b000, o_dnext, o_drep, o_soc, o_avg_i, o_avg_v};
    assign m_tuser = {o_measured, o_mode, o_channel};
endmodule

@@ rtl/cccv_checker.sv @@
// Port-level checks of the charge controller and their binding to the top level.
module cccv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [4:0]  m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[38:32] <= 7'd100 && m_tdata[52:46] <= 7'd100)
        else $error("soc or duty out of range");

    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[4] |-> m_tdata[31:0] == 32'd0 && m_tdata[52:39] == 14'd0
                                   && m_tuser[3:2] == 2'd0)
        else $error("unmeasured result carries data");

    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3:2] != 2'd0 |->
            ({1'b0, m_tdata[52:46]} == {1'b0, m_tdata[45:39]} + 8'd1) ||
            ({1'b0, m_tdata[52:46]} + 8'd1 == {1'b0, m_tdata[45:39]}) ||
            (m_tdata[52:46] == m_tdata[45:39]))
        else $error("duty step larger than one");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind cc_cv_charge_controller cccv_checker u_cccv_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);
